>>> rtl/core/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants, codes and the sequencer state type for the triangle
// tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // default field widths
  localparam int POS_WIDTH_DEF = 32;
  localparam int UV_WIDTH_DEF  = 24;

  // result format: Q16.16, 32 bits
  localparam int OUT_W = 32;
  localparam int FRAC  = 16;

  // quotient bits worked out by the divider: bit 33 set means saturation
  localparam int QW = OUT_W + 2;

  // corner codes
  localparam int CORNER_W = 2;
  localparam logic [CORNER_W-1:0] CORNER_0 = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_1 = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_2 = 2'd2;

  // job codes: determinant, then tangent x/y/z, then bitangent x/y/z
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] JOB_DET = 3'd0;
  localparam logic [JOB_W-1:0] JOB_TX  = 3'd1;
  localparam logic [JOB_W-1:0] JOB_TY  = 3'd2;
  localparam logic [JOB_W-1:0] JOB_TZ  = 3'd3;
  localparam logic [JOB_W-1:0] JOB_BX  = 3'd4;
  localparam logic [JOB_W-1:0] JOB_BY  = 3'd5;
  localparam logic [JOB_W-1:0] JOB_BZ  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_MAG,
    ST_DIV,
    ST_RND,
    ST_FIN,
    ST_PUSH
  } state_t;

endpackage

>>> rtl/core/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Tangent and bitangent of a triangle from its corner positions and texture
// coordinates, using one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  corner, pos_x/y/z, tex_u/v
//  out      output     out_valid/out_stall  tangent_x/y/z, bitangent_x/y/z,
//                                           degenerate, clipped
//
//  Corner 0 and 1 transfers are held and corner 3 transfers dropped; none of
//  them busies the block. A corner 2 transfer is worked as shift-add products of
//  UV_WIDTH+1 steps and 34-step restoring divides, all on the one adder.
//  A zero determinant skips the tangent jobs and goes straight to the result.
//  in_stall is high while a triangle is being worked; the result register
//  lets corners of the next triangle in while out_stall holds a result.
//  Synchronous active-low reset; held corners are not cleared.
// ----------------------------------------------------------------------------
module triangle_tangent_basis #(
  parameter int POS_WIDTH = ttb_pkg::POS_WIDTH_DEF,
  parameter int UV_WIDTH  = ttb_pkg::UV_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ttb_pkg::CORNER_W-1:0]        in_corner,
  input  logic signed [POS_WIDTH-1:0]         in_pos_x,
  input  logic signed [POS_WIDTH-1:0]         in_pos_y,
  input  logic signed [POS_WIDTH-1:0]         in_pos_z,
  input  logic signed [UV_WIDTH-1:0]          in_tex_u,
  input  logic signed [UV_WIDTH-1:0]          in_tex_v,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_tangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_tangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_tangent_z,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_bitangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_bitangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0]    out_bitangent_z,
  output logic                                out_degenerate,
  output logic                                out_clipped
);
  import ttb_pkg::*;

  localparam int MW    = UV_WIDTH + 1;                 // uv delta
  localparam int EW    = POS_WIDTH + 1;                // edge
  localparam int NUMW  = POS_WIDTH + UV_WIDTH + 3;     // numerator
  localparam int DETW  = 2 * UV_WIDTH + 3;             // determinant
  localparam int ACCW  = (NUMW > DETW) ? NUMW : DETW;
  localparam int REMW  = ACCW + FRAC;
  localparam int DSHW  = ACCW + QW - 1;
  localparam int UW    = DSHW + 1;
  localparam int CNTN  = (MW > QW) ? MW : QW;
  localparam int CNTW  = $clog2(CNTN);
  localparam logic [QW:0] LIM_POS = (QW + 1)'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [QW:0] LIM_NEG = (QW + 1)'(64'd1 << (OUT_W - 1));

  state_t state_r, state_nxt;

  logic [CNTW-1:0]  cnt_r;
  logic [JOB_W-1:0] job_r;
  logic             pass_r;
  logic             out_valid_r;

  // held corners and captured deltas
  logic signed [POS_WIDTH-1:0] hp_r [6];
  logic signed [UV_WIDTH-1:0]  ht_r [4];
  logic signed [POS_WIDTH-1:0] pos_in [3];
  logic signed [EW-1:0]        e1_r [3];
  logic signed [EW-1:0]        e2_r [3];
  logic signed [MW-1:0]        du1_r, dv1_r, du2_r, dv2_r;

  // working registers
  logic [MW-1:0]          mplr_r;
  logic signed [ACCW-1:0] mcand_r;
  logic signed [ACCW-1:0] acc_r;
  logic [ACCW-1:0]        det_mag_r;
  logic                   det_neg_r;
  logic [REMW-1:0]        rem_r;
  logic [DSHW-1:0]        dsh_r;
  logic [QW-1:0]          quo_r;
  logic                   qneg_r;
  logic                   rnd_r;
  logic                   clip_r;
  logic                   deg_r;
  logic [OUT_W-1:0]       res_r [6];

  logic [OUT_W-1:0] out_tx_r, out_ty_r, out_tz_r, out_bx_r, out_by_r, out_bz_r;
  logic             out_deg_r, out_clip_r;

  // shared unit
  logic [UW-1:0] unit_a, unit_b, unit_sum;
  logic          unit_sub;

  logic                   in_xfer;
  logic                   push_ok;
  logic                   mul_last, div_last;
  logic                   acc_zero;
  logic [1:0]             kidx;
  logic signed [EW-1:0]   e1_sel, e2_sel;
  logic [MW-1:0]          op_mplr;
  logic signed [ACCW-1:0] op_mcand;
  logic [QW:0]            fin_q, fin_lim;
  logic                   fin_over;
  logic [OUT_W-1:0]       fin_mag, fin_val;

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;

  assign in_xfer  = in_valid && !in_stall;
  assign push_ok  = !out_valid_r || !out_stall;
  assign mul_last = (cnt_r == CNTW'(MW - 1));
  assign div_last = (cnt_r == CNTW'(QW - 1));
  assign acc_zero = (acc_r == '0);

  assign unit_sum = unit_a + (unit_b ^ {UW{unit_sub}}) + UW'(unit_sub);

  // operand selection for the current job and pass
  always_comb begin
    kidx = 2'd0;
    case (job_r)
      JOB_TY, JOB_BY: kidx = 2'd1;
      JOB_TZ, JOB_BZ: kidx = 2'd2;
      default:        kidx = 2'd0;
    endcase
  end

  assign e1_sel = e1_r[kidx];
  assign e2_sel = e2_r[kidx];

  always_comb begin
    op_mplr  = '0;
    op_mcand = '0;
    case (job_r)
      JOB_DET: begin
        op_mplr  = pass_r ? du2_r : du1_r;
        op_mcand = pass_r ? ACCW'(dv1_r) : ACCW'(dv2_r);
      end
      JOB_TX, JOB_TY, JOB_TZ: begin
        op_mplr  = pass_r ? dv1_r : dv2_r;
        op_mcand = pass_r ? ACCW'(e2_sel) : ACCW'(e1_sel);
      end
      JOB_BX, JOB_BY, JOB_BZ: begin
        op_mplr  = pass_r ? du2_r : du1_r;
        op_mcand = pass_r ? ACCW'(e1_sel) : ACCW'(e2_sel);
      end
      default: begin
        op_mplr  = '0;
        op_mcand = '0;
      end
    endcase
  end

  // rounding, saturation and sign of one quotient
  always_comb begin
    fin_q    = {1'b0, quo_r} + (QW + 1)'(rnd_r);
    fin_lim  = qneg_r ? LIM_NEG : LIM_POS;
    fin_over = (fin_q > fin_lim);
    fin_mag  = fin_over ? fin_lim[OUT_W-1:0] : fin_q[OUT_W-1:0];
    fin_val  = qneg_r ? (OUT_W'(0) - fin_mag) : fin_mag;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer && in_corner == CORNER_2) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_last) state_nxt = pass_r ? ST_MAG : ST_LOAD;
      end
      ST_MAG: begin
        if (job_r == JOB_DET) state_nxt = acc_zero ? ST_PUSH : ST_LOAD;
        else state_nxt = ST_DIV;
      end
      ST_DIV: if (div_last) state_nxt = ST_RND;
      ST_RND: state_nxt = ST_FIN;
      ST_FIN: state_nxt = (job_r == JOB_BZ) ? ST_PUSH : ST_LOAD;
      ST_PUSH: if (push_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: stall and shared unit controls
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    case (state_r)
      ST_MUL: begin
        unit_a   = UW'(acc_r);
        unit_b   = UW'(mcand_r);
        // multiplier sign bit has negative weight; second product subtracts
        unit_sub = mul_last ^ pass_r;
      end
      ST_MAG: begin
        unit_b   = UW'(acc_r);
        unit_sub = acc_r[ACCW-1];
      end
      ST_DIV: begin
        unit_a   = UW'(rem_r);
        unit_b   = UW'(dsh_r);
        unit_sub = 1'b1;
      end
      ST_RND: begin
        unit_a   = UW'({rem_r, 1'b0});
        unit_b   = UW'(det_mag_r);
        unit_sub = 1'b1;
      end
      default: begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      job_r       <= JOB_DET;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          job_r  <= JOB_DET;
          pass_r <= 1'b0;
        end
        ST_LOAD: cnt_r <= '0;
        ST_MUL: begin
          cnt_r <= cnt_r + CNTW'(1);
          if (mul_last && !pass_r) pass_r <= 1'b1;
        end
        ST_MAG: begin
          cnt_r  <= '0;
          pass_r <= 1'b0;
          if (job_r == JOB_DET) job_r <= JOB_TX;
        end
        ST_DIV: cnt_r <= cnt_r + CNTW'(1);
        ST_FIN: begin
          pass_r <= 1'b0;
          job_r  <= job_r + JOB_W'(1);
        end
        default: ;
      endcase
      if (state_r == ST_PUSH && push_ok) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_corner)
            CORNER_0: begin
              for (int k = 0; k < 3; k++) hp_r[k] <= pos_in[k];
              ht_r[0] <= in_tex_u;
              ht_r[1] <= in_tex_v;
            end
            CORNER_1: begin
              for (int k = 0; k < 3; k++) hp_r[3 + k] <= pos_in[k];
              ht_r[2] <= in_tex_u;
              ht_r[3] <= in_tex_v;
            end
            CORNER_2: begin
              for (int k = 0; k < 3; k++) begin
                e1_r[k] <= EW'(hp_r[3 + k]) - EW'(hp_r[k]);
                e2_r[k] <= EW'(pos_in[k]) - EW'(hp_r[k]);
              end
              du1_r  <= MW'(ht_r[2]) - MW'(ht_r[0]);
              dv1_r  <= MW'(ht_r[3]) - MW'(ht_r[1]);
              du2_r  <= MW'(in_tex_u) - MW'(ht_r[0]);
              dv2_r  <= MW'(in_tex_v) - MW'(ht_r[1]);
              clip_r <= 1'b0;
              deg_r  <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        mplr_r  <= op_mplr;
        mcand_r <= op_mcand;
        if (!pass_r) acc_r <= '0;
      end
      ST_MUL: begin
        if (mplr_r[0]) acc_r <= unit_sum[ACCW-1:0];
        mplr_r  <= mplr_r >> 1;
        mcand_r <= mcand_r <<< 1;
      end
      ST_MAG: begin
        if (job_r == JOB_DET) begin
          det_mag_r <= unit_sum[ACCW-1:0];
          det_neg_r <= acc_r[ACCW-1];
          deg_r     <= acc_zero;
        end else begin
          rem_r  <= {unit_sum[ACCW-1:0], {FRAC{1'b0}}};
          dsh_r  <= {det_mag_r, {(QW - 1){1'b0}}};
          qneg_r <= acc_r[ACCW-1] ^ det_neg_r;
        end
      end
      ST_DIV: begin
        if (!unit_sum[UW-1]) rem_r <= unit_sum[REMW-1:0];
        quo_r <= {quo_r[QW-2:0], ~unit_sum[UW-1]};
        dsh_r <= dsh_r >> 1;
      end
      ST_RND: rnd_r <= ~unit_sum[UW-1];
      ST_FIN: begin
        res_r[job_r - JOB_TX] <= fin_val;
        clip_r                <= clip_r | fin_over;
      end
      ST_PUSH: begin
        if (push_ok) begin
          out_tx_r   <= deg_r ? '0 : res_r[0];
          out_ty_r   <= deg_r ? '0 : res_r[1];
          out_tz_r   <= deg_r ? '0 : res_r[2];
          out_bx_r   <= deg_r ? '0 : res_r[3];
          out_by_r   <= deg_r ? '0 : res_r[4];
          out_bz_r   <= deg_r ? '0 : res_r[5];
          out_deg_r  <= deg_r;
          out_clip_r <= clip_r & ~deg_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_tx_r;
  assign out_tangent_y   = out_ty_r;
  assign out_tangent_z   = out_tz_r;
  assign out_bitangent_x = out_bx_r;
  assign out_bitangent_y = out_by_r;
  assign out_bitangent_z = out_bz_r;
  assign out_degenerate  = out_deg_r;
  assign out_clipped     = out_clip_r;

endmodule

>>> rtl/core/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks for triangle_tangent_basis, bound to the top level.
// ----------------------------------------------------------------------------
module ttb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [ttb_pkg::CORNER_W-1:0]      in_corner,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_tangent_x,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_tangent_y,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_tangent_z,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_bitangent_x,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_bitangent_y,
  input logic signed [ttb_pkg::OUT_W-1:0]  out_bitangent_z,
  input logic                              out_degenerate,
  input logic                              out_clipped
);
  import ttb_pkg::*;

  // a held result stays put until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tangent_x) &&
      $stable(out_tangent_y) && $stable(out_tangent_z) &&
      $stable(out_bitangent_x) && $stable(out_bitangent_y) &&
      $stable(out_bitangent_z) && $stable(out_degenerate) && $stable(out_clipped))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // completing corner busies the block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_corner == CORNER_2 |=> in_stall)
    else $error("input not stalled while working a triangle");

  // no result appears straight after an input transfer
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result raised the cycle after an input transfer");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_tangent_x == '0 && out_tangent_y == '0 &&
      out_tangent_z == '0 && out_bitangent_x == '0 && out_bitangent_y == '0 &&
      out_bitangent_z == '0 && !out_clipped)
    else $error("degenerate result with non-zero vectors or clip");

endmodule

bind triangle_tangent_basis ttb_checker u_ttb_checker (.*);

>>> tb/triangle_tangent_basis_tb.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_tb
// Streams triangle corners into the block under several sender and receiver
// idling patterns. A local predictor holds corners 0 and 1 and computes the
// expected tangent, bitangent and flags of each corner 2 transfer at full
// width, and every result transfer is checked against the oldest one due.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttb_pkg::*;

  localparam int POS_W = POS_WIDTH_DEF;
  localparam int UV_W  = UV_WIDTH_DEF;
  localparam logic [CORNER_W-1:0] CORNER_SKIP = 2'd3;

  // worst-case cycles for one triangle, from the block's sequencer states
  localparam int TRI_CYCLES   = 14 * (UV_W + 1) + 238;
  localparam int TAIL_CYCLES  = TRI_CYCLES + 16;
  localparam int STALL_LIMIT  = 40 * TRI_CYCLES;
  localparam int PHASE_ITEMS  = 425;
  localparam int REPORT_LIMIT = 10;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC);
  localparam logic [UV_W-1:0]  UV_ONE  = UV_W'(1 << FRAC);
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [UV_W-1:0]  UV_MAX  = {1'b0, {(UV_W-1){1'b1}}};
  localparam logic [UV_W-1:0]  UV_MIN  = {1'b1, {(UV_W-1){1'b0}}};

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [POS_W-1:0]    pz;
    logic [UV_W-1:0]     u;
    logic [UV_W-1:0]     v;
  } corner_item_t;

  // vec: tangent x/y/z then bitangent x/y/z
  typedef struct packed {
    logic [5:0][OUT_W-1:0] vec;
    logic                  degen;
    logic                  clip;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CORNER_W-1:0]        in_corner = '0;
  logic signed [POS_W-1:0]    in_pos_x = '0;
  logic signed [POS_W-1:0]    in_pos_y = '0;
  logic signed [POS_W-1:0]    in_pos_z = '0;
  logic signed [UV_W-1:0]     in_tex_u = '0;
  logic signed [UV_W-1:0]     in_tex_v = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [OUT_W-1:0]    out_tangent_x;
  logic signed [OUT_W-1:0]    out_tangent_y;
  logic signed [OUT_W-1:0]    out_tangent_z;
  logic signed [OUT_W-1:0]    out_bitangent_x;
  logic signed [OUT_W-1:0]    out_bitangent_y;
  logic signed [OUT_W-1:0]    out_bitangent_z;
  logic                       out_degenerate;
  logic                       out_clipped;

  triangle_tangent_basis #(
    .POS_WIDTH(POS_W),
    .UV_WIDTH (UV_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_corner      (in_corner),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_tex_u       (in_tex_u),
    .in_tex_v       (in_tex_v),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tangent_x  (out_tangent_x),
    .out_tangent_y  (out_tangent_y),
    .out_tangent_z  (out_tangent_z),
    .out_bitangent_x(out_bitangent_x),
    .out_bitangent_y(out_bitangent_y),
    .out_bitangent_z(out_bitangent_z),
    .out_degenerate (out_degenerate),
    .out_clipped    (out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  corner_item_t corner_queue [$];
  basis_t       basis_due [$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int gen_items    = 0;
  int corner_xfers = 0;
  int tri_checked  = 0;
  int degen_seen   = 0;
  int clip_seen    = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;

  // corners held by the predictor
  logic signed [POS_W-1:0] held_pos [2][3];
  logic signed [UV_W-1:0]  held_uv  [2][2];

  corner_item_t next_item;
  basis_t       got;
  basis_t       want;

  // round(num * 2^16 / den), ties away from zero, saturated to 32 bits
  function automatic logic [OUT_W-1:0] q16_quotient(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic clip);
    logic             neg;
    logic [127:0]     n_mag;
    logic [127:0]     d_mag;
    logic [127:0]     q;
    logic [127:0]     limit;
    logic [OUT_W-1:0] mag;
    neg   = num[127] ^ den[127];
    n_mag = num[127] ? -num : num;
    d_mag = den[127] ? -den : den;
    q     = ((n_mag << (FRAC + 1)) + d_mag) / (d_mag << 1);
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > limit) begin
      clip = 1'b1;
      q    = limit;
    end
    mag = q[OUT_W-1:0];
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // tangent frame of the held corners and a closing corner 2
  function automatic basis_t tangent_basis(input corner_item_t it);
    basis_t             r;
    logic signed [127:0] p  [3];
    logic signed [127:0] e1 [3];
    logic signed [127:0] e2 [3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    logic               clip;
    p[0] = $signed(it.px);
    p[1] = $signed(it.py);
    p[2] = $signed(it.pz);
    for (int k = 0; k < 3; k++) begin
      e1[k] = held_pos[1][k] - held_pos[0][k];
      e2[k] = p[k] - held_pos[0][k];
    end
    du1 = held_uv[1][0] - held_uv[0][0];
    dv1 = held_uv[1][1] - held_uv[0][1];
    du2 = $signed(it.u) - held_uv[0][0];
    dv2 = $signed(it.v) - held_uv[0][1];
    det = du1 * dv2 - du2 * dv1;
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r.vec[k]     = q16_quotient(dv2 * e1[k] - dv1 * e2[k], det, clip);
      r.vec[3 + k] = q16_quotient(du1 * e2[k] - du2 * e1[k], det, clip);
    end
    r.clip = clip;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] basis_field(input basis_t b, input int k);
    if (k < 6) return b.vec[k];
    return (k == 6) ? OUT_W'(b.degen) : OUT_W'(b.clip);
  endfunction

  // ---- stimulus helpers ----

  function automatic logic [POS_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return POS_W'($urandom_range(32'h0020_0000) - 32'h0010_0000);
    if (roll < 75) return POS_W'($urandom_range(32'h0200_0000) - 32'h0100_0000);
    if (roll < 95) return POS_W'($urandom());
    case ($urandom_range(3))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [UV_W-1:0] pick_uv();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return UV_W'($urandom_range(32'h0002_0000) - 32'h0001_0000);
    if (roll < 85) return UV_W'($urandom());
    if (roll < 95) return UV_W'($urandom_range(128) - 64);
    case ($urandom_range(3))
      0:       return UV_MAX;
      1:       return UV_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic push_corner(input logic [CORNER_W-1:0] c,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z,
                             input logic [UV_W-1:0] u, input logic [UV_W-1:0] v);
    corner_item_t it;
    it = '{corner: c, px: x, py: y, pz: z, u: u, v: v};
    corner_queue.push_back(it);
    if (c != CORNER_SKIP) gen_items++;
  endtask

  task automatic push_random_corner(input logic [CORNER_W-1:0] c);
    push_corner(c, pick_pos(), pick_pos(), pick_pos(), pick_uv(), pick_uv());
  endtask

  // flat: texture coordinates placed so that the determinant is zero
  task automatic push_triangle(input bit flat);
    logic [POS_W-1:0] p [3][3];
    logic [UV_W-1:0]  t [3][2];
    int               sel;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) p[c][k] = pick_pos();
      t[c][0] = pick_uv();
      t[c][1] = pick_uv();
    end
    if (flat) begin
      sel = $urandom_range(2);
      if (sel == 0) t[2] = t[0];
      else if (sel == 1) t[1] = t[0];
      else t[2] = t[1];
    end
    if ($urandom_range(3) == 0) begin
      push_corner(CORNER_1, p[1][0], p[1][1], p[1][2], t[1][0], t[1][1]);
      push_corner(CORNER_0, p[0][0], p[0][1], p[0][2], t[0][0], t[0][1]);
    end else begin
      push_corner(CORNER_0, p[0][0], p[0][1], p[0][2], t[0][0], t[0][1]);
      push_corner(CORNER_1, p[1][0], p[1][1], p[1][2], t[1][0], t[1][1]);
    end
    push_corner(CORNER_2, p[2][0], p[2][1], p[2][2], t[2][0], t[2][1]);
  endtask

  task automatic push_directed();
    // unit right-angle triangle: tangent along x, bitangent along y
    push_corner(CORNER_0, '0, '0, '0, '0, '0);
    push_corner(CORNER_1, POS_ONE, '0, '0, UV_ONE, '0);
    push_corner(CORNER_2, '0, POS_ONE, '0, '0, UV_ONE);
    push_corner(CORNER_SKIP, '1, '1, '1, '1, '1);
    // repeated closing corners at the field extremes, then one on corner 0's uv
    push_corner(CORNER_2, POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MAX);
    push_corner(CORNER_2, POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MIN);
    push_corner(CORNER_2, POS_ONE, POS_ONE, '0, '0, '0);
    // half-LSB results in both signs: rounding ties
    push_corner(CORNER_1, POS_W'(1), '1, POS_W'(3), UV_W'(32'h2_0000), '0);
    push_corner(CORNER_2, '1, '0, '0, '0, UV_W'(1));
    push_corner(CORNER_0, POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MIN);
    push_corner(CORNER_1, POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MAX);
    push_corner(CORNER_2, '0, '0, '0, UV_MAX, UV_MIN);
    push_corner(CORNER_0, POS_MAX, POS_MIN, '0, UV_MAX, UV_MIN);
    push_corner(CORNER_1, '1, POS_W'(1), POS_MIN, UV_W'(1), '1);
    push_corner(CORNER_2, POS_MIN, POS_MAX, '1, UV_MIN, UV_MAX);
  endtask

  task automatic push_random_phase();
    int made;
    int roll;
    made = gen_items;
    while (gen_items - made < PHASE_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 68) begin
        push_triangle(1'b0);
      end else if (roll < 76) begin
        push_triangle(1'b1);
      end else if (roll < 86) begin
        push_random_corner(CORNER_2);
      end else if (roll < 94) begin
        push_random_corner($urandom_range(1) ? CORNER_1 : CORNER_0);
        push_random_corner(CORNER_2);
      end else begin
        push_random_corner(CORNER_SKIP);
      end
    end
  endtask

  // sender holds off until the block has returned everything owed
  task automatic drain();
    while (corner_queue.size() != 0 || in_valid || basis_due.size() != 0)
      @(negedge clk);
  endtask

  // ---- driver ----

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (corner_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_item = corner_queue.pop_front();
        in_valid  <= 1'b1;
        in_corner <= next_item.corner;
        in_pos_x  <= next_item.px;
        in_pos_y  <= next_item.py;
        in_pos_z  <= next_item.pz;
        in_tex_u  <= next_item.u;
        in_tex_v  <= next_item.v;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---- predictor: runs on every accepted corner transfer ----

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      corner_xfers++;
      if (in_corner == CORNER_0 || in_corner == CORNER_1) begin
        held_pos[in_corner[0]][0] = in_pos_x;
        held_pos[in_corner[0]][1] = in_pos_y;
        held_pos[in_corner[0]][2] = in_pos_z;
        held_uv[in_corner[0]][0]  = in_tex_u;
        held_uv[in_corner[0]][1]  = in_tex_v;
      end else if (in_corner == CORNER_2) begin
        basis_due.push_back(tangent_basis('{corner: in_corner, px: in_pos_x,
                                            py: in_pos_y, pz: in_pos_z,
                                            u: in_tex_u, v: in_tex_v}));
      end
    end
  end

  // ---- result checker ----

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.vec[0] = out_tangent_x;
      got.vec[1] = out_tangent_y;
      got.vec[2] = out_tangent_z;
      got.vec[3] = out_bitangent_x;
      got.vec[4] = out_bitangent_y;
      got.vec[5] = out_bitangent_z;
      got.degen  = out_degenerate;
      got.clip   = out_clipped;
      if (basis_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result transfer with none due: %h", $realtime, got);
      end else begin
        want = basis_due.pop_front();
        tri_checked++;
        if (want.degen) degen_seen++;
        if (want.clip)  clip_seen++;
        for (int k = 0; k < 8; k++) begin
          if (basis_field(got, k) !== basis_field(want, k)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: triangle %0d field %0d: expected %h, got %h", $realtime,
                       tri_checked, k, basis_field(want, k), basis_field(got, k));
          end
        end
      end
    end
  end

  // ---- watchdog: cycles without any transfer ----

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("triangle_tangent_basis: mismatch");
        $finish;
      end
    end
  end

  // ---- phases ----

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_directed();
    push_random_phase();
    drain();

    send_gap_pct = 46;
    push_random_phase();
    drain();

    send_gap_pct = 0;
    stall_pct    = 46;
    push_random_phase();
    drain();

    send_gap_pct = 33;
    stall_pct    = 33;
    push_random_phase();
    drain();

    // corner-only transfers may still be settling; catch any stray result
    repeat (TAIL_CYCLES) @(negedge clk);
    mismatches += basis_due.size();

    $display("Sent %0d corner transfers over four idling patterns;", corner_xfers);
    $display("checked %0d triangles, %0d degenerate and %0d saturated.",
             tri_checked, degen_seen, clip_seen);
    if (mismatches == 0) begin
      $display("triangle_tangent_basis: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("triangle_tangent_basis: mismatch");
    end
    $finish;
  end

endmodule
